// ----- hdl/eepws_pkg.sv -----
// Shared types and codes for the EEPROM page write scheduler.
package eepws_pkg;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_status;

    localparam t_opcode OP_WRITE_REQ = 2'd0;
    localparam t_opcode OP_XFER_DONE = 2'd1;
    localparam t_opcode OP_TICK      = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_ZERO_LEN = 2'd2;
    localparam t_status ST_IGNORED  = 2'd3;

    localparam logic [7:0] WAIT_TICKS_RESET = 8'd11;

endpackage

// ----- hdl/eeprom_page_write_scheduler_unit.sv -----
// EEPROM page write scheduler: request queue and page-bounded chunk issue.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  event in  | i_start / o_busy          | i_opcode, i_req_address, i_req_length,
//            |                           | i_req_handle
//  result    | o_res_valid (strobe)      | o_status, o_cmd_*, o_done_*, o_queue_count,
//            |                           | o_busy_res
//  config    | i_cfg_valid / o_cfg_ready | i_cfg_data (wait_ticks)
//
// One event per clock: each transaction is handled by a single pass of logic from the
// event ports and the queue head registers into the result registers, so the result
// strobe rises in the cycle after acceptance. o_busy stays low; the next request is read
// from the queue slot after the head with one combinational array read.
// Synchronous active-low reset clears pointers, counters and state flags, not the queue.
// The receiver cannot stall, so results are never held back. PAGE_SIZE is a power of two.
module eeprom_page_write_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PAGE_SIZE   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  eepws_pkg::t_opcode  i_opcode,
    input  logic [15:0]         i_req_address,
    input  logic [15:0]         i_req_length,
    input  logic [15:0]         i_req_handle,
    output logic                o_res_valid,
    output eepws_pkg::t_status  o_status,
    output logic                o_cmd_valid,
    output logic [15:0]         o_cmd_address,
    output logic [6:0]          o_cmd_length,
    output logic [15:0]         o_cmd_offset,
    output logic [15:0]         o_cmd_handle,
    output logic                o_done_valid,
    output logic [15:0]         o_done_handle,
    output logic [4:0]          o_queue_count,
    output logic                o_busy_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import eepws_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PAGE_BITS = $clog2(PAGE_SIZE);
    localparam int LEN_W     = PAGE_BITS + 1;

    // queue storage, no reset
    logic [15:0] r_q_addr   [QUEUE_DEPTH];
    logic [15:0] r_q_len    [QUEUE_DEPTH];
    logic [15:0] r_q_handle [QUEUE_DEPTH];

    logic [PTR_W-1:0] r_ins_ptr, n_ins_ptr;
    logic [PTR_W-1:0] r_srv_ptr, n_srv_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_writing, n_writing;
    logic             r_waiting, n_waiting;
    logic [15:0]      r_written, n_written;
    logic [LEN_W-1:0] r_last_len, n_last_len;
    logic [7:0]       r_wait_cnt, n_wait_cnt;
    logic [7:0]       r_wait_ticks;

    // request in progress
    logic [15:0] r_cur_addr, n_cur_addr;
    logic [15:0] r_cur_len, n_cur_len;
    logic [15:0] r_cur_handle, n_cur_handle;

    logic        r_res_valid;
    t_status     r_status, n_status;
    logic        r_cmd_valid, n_cmd_valid;
    logic [15:0] r_cmd_address, n_cmd_address;
    logic [6:0]  r_cmd_length, n_cmd_length;
    logic [15:0] r_cmd_offset, n_cmd_offset;
    logic [15:0] r_cmd_handle, n_cmd_handle;
    logic        r_done_valid, n_done_valid;
    logic [15:0] r_done_handle, n_done_handle;

    logic             w_accept;
    logic             w_insert;
    logic [PTR_W-1:0] w_srv_next;
    logic [PTR_W-1:0] w_ins_next;

    // chunk unit operands and results
    logic             w_issue;
    logic [15:0]      w_base;
    logic [15:0]      w_len;
    logic [15:0]      w_done_bytes;
    logic [15:0]      w_handle;
    logic [15:0]      w_chunk_addr;
    logic [LEN_W-1:0] w_room;
    logic [15:0]      w_remain;
    logic [15:0]      w_chunk_len;

    assign w_accept    = i_start & ~o_busy;
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign w_srv_next = (r_srv_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_srv_ptr + 1'b1;
    assign w_ins_next = (r_ins_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_ins_ptr + 1'b1;

    // page-bounded chunk: stop at the page end or at the request end
    assign w_chunk_addr = w_base + w_done_bytes;
    assign w_room       = LEN_W'(PAGE_SIZE) - {1'b0, w_chunk_addr[PAGE_BITS-1:0]};
    assign w_remain     = w_len - w_done_bytes;
    assign w_chunk_len  = (w_remain < 16'(w_room)) ? w_remain : 16'(w_room);

    always_comb begin
        n_ins_ptr     = r_ins_ptr;
        n_srv_ptr     = r_srv_ptr;
        n_count       = r_count;
        n_writing     = r_writing;
        n_waiting     = r_waiting;
        n_written     = r_written;
        n_last_len    = r_last_len;
        n_wait_cnt    = r_wait_cnt;
        n_cur_addr    = r_cur_addr;
        n_cur_len     = r_cur_len;
        n_cur_handle  = r_cur_handle;
        n_status      = ST_IGNORED;
        n_done_valid  = 1'b0;
        n_done_handle = '0;
        w_insert      = 1'b0;
        w_issue       = 1'b0;
        w_base        = r_cur_addr;
        w_len         = r_cur_len;
        w_done_bytes  = r_written;
        w_handle      = r_cur_handle;

        if (w_accept) begin
            case (i_opcode)
                OP_WRITE_REQ: begin
                    if (i_req_length == '0) begin
                        n_status = ST_ZERO_LEN;
                    end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status  = ST_OK;
                        w_insert  = 1'b1;
                        n_ins_ptr = w_ins_next;
                        n_count   = r_count + 1'b1;
                        if (!r_writing) begin
                            // start this request at once
                            n_writing    = 1'b1;
                            n_waiting    = 1'b0;
                            n_written    = '0;
                            n_cur_addr   = i_req_address;
                            n_cur_len    = i_req_length;
                            n_cur_handle = i_req_handle;
                            w_issue      = 1'b1;
                            w_base       = i_req_address;
                            w_len        = i_req_length;
                            w_done_bytes = '0;
                            w_handle     = i_req_handle;
                        end
                    end
                end
                OP_XFER_DONE: begin
                    if (r_writing && !r_waiting) begin
                        n_status   = ST_OK;
                        n_written  = r_written + 16'(r_last_len);
                        n_waiting  = 1'b1;
                        n_wait_cnt = (r_wait_ticks == '0) ? 8'd1 : r_wait_ticks;
                    end
                end
                OP_TICK: begin
                    if (r_waiting) begin
                        n_status   = ST_OK;
                        n_wait_cnt = (r_wait_cnt == '0) ? '0 : r_wait_cnt - 1'b1;
                        if (r_wait_cnt <= 8'd1) begin
                            n_waiting = 1'b0;
                            if (r_written < r_cur_len) begin
                                w_issue = 1'b1;
                            end else begin
                                // retire the head, then start the next queued request if one is waiting
                                n_done_valid  = 1'b1;
                                n_done_handle = r_cur_handle;
                                n_srv_ptr     = w_srv_next;
                                n_count       = (r_count == '0) ? '0 : r_count - 1'b1;
                                n_writing     = 1'b0;
                                n_written     = '0;
                                if (r_count > CNT_W'(1)) begin
                                    n_writing    = 1'b1;
                                    n_cur_addr   = r_q_addr[w_srv_next];
                                    n_cur_len    = r_q_len[w_srv_next];
                                    n_cur_handle = r_q_handle[w_srv_next];
                                    w_issue      = 1'b1;
                                    w_base       = r_q_addr[w_srv_next];
                                    w_len        = r_q_len[w_srv_next];
                                    w_done_bytes = '0;
                                    w_handle     = r_q_handle[w_srv_next];
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_status = ST_IGNORED;
                end
            endcase
        end

        n_cmd_valid   = w_issue;
        n_cmd_address = w_issue ? w_chunk_addr : '0;
        n_cmd_length  = w_issue ? w_chunk_len[6:0] : '0;
        n_cmd_offset  = w_issue ? w_done_bytes : '0;
        n_cmd_handle  = w_issue ? w_handle : '0;
        if (w_issue) begin
            n_last_len = w_chunk_len[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_q_addr[r_ins_ptr]   <= i_req_address;
            r_q_len[r_ins_ptr]    <= i_req_length;
            r_q_handle[r_ins_ptr] <= i_req_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_ptr    <= '0;
            r_srv_ptr    <= '0;
            r_count      <= '0;
            r_writing    <= 1'b0;
            r_waiting    <= 1'b0;
            r_written    <= '0;
            r_last_len   <= '0;
            r_wait_cnt   <= '0;
            r_wait_ticks <= WAIT_TICKS_RESET;
            r_res_valid  <= 1'b0;
        end else begin
            r_ins_ptr   <= n_ins_ptr;
            r_srv_ptr   <= n_srv_ptr;
            r_count     <= n_count;
            r_writing   <= n_writing;
            r_waiting   <= n_waiting;
            r_written   <= n_written;
            r_last_len  <= n_last_len;
            r_wait_cnt  <= n_wait_cnt;
            r_res_valid <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_wait_ticks <= i_cfg_data;
            end
        end
    end

    // head request and result payload
    always_ff @(posedge i_clk) begin
        r_cur_addr    <= n_cur_addr;
        r_cur_len     <= n_cur_len;
        r_cur_handle  <= n_cur_handle;
        r_status      <= n_status;
        r_cmd_valid   <= n_cmd_valid;
        r_cmd_address <= n_cmd_address;
        r_cmd_length  <= n_cmd_length;
        r_cmd_offset  <= n_cmd_offset;
        r_cmd_handle  <= n_cmd_handle;
        r_done_valid  <= n_done_valid;
        r_done_handle <= n_done_handle;
    end

    assign o_res_valid   = r_res_valid;
    assign o_status      = r_status;
    assign o_cmd_valid   = r_cmd_valid;
    assign o_cmd_address = r_cmd_address;
    assign o_cmd_length  = r_cmd_length;
    assign o_cmd_offset  = r_cmd_offset;
    assign o_cmd_handle  = r_cmd_handle;
    assign o_done_valid  = r_done_valid;
    assign o_done_handle = r_done_handle;
    assign o_queue_count = 5'(r_count);
    assign o_busy_res    = r_writing;

    a_writing_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_writing |-> (r_count != '0))
        else $error("writing with an empty queue");

    a_wait_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> r_writing)
        else $error("waiting while no request is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != CNT_W'(QUEUE_DEPTH)) |-> (r_ins_ptr != r_srv_ptr))
        else $error("pointers collide on a partly filled queue");

    a_issue_starts_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_writing) |-> (r_cmd_valid && r_res_valid))
        else $error("request started without a chunk command");

endmodule
